// ===== design/stsq_pkg.sv =====
`timescale 1ns / 1ps

package stsq_pkg;

    localparam int COUNT_BITS = 16;
    localparam int FREQ_BITS  = 16;
    localparam int CMP_BITS   = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    localparam int IN_DATA_BITS  = 48;
    localparam int OUT_DATA_BITS = 24;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    typedef enum logic [1:0] {
        LOOP_NONE    = 2'd0,
        LOOP_REPEAT  = 2'd1,
        LOOP_COUNTED = 2'd2
    } loop_mode_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PLAYBACK_ENABLE = 3'd0,
        CFG_EFFECT_FLAGS    = 3'd1,
        CFG_SWEEP_STEP      = 3'd2,
        CFG_SWEEP_TRIGGER   = 3'd3,
        CFG_SWEEP_HOLD      = 3'd4,
        CFG_GATE_TRIGGER    = 3'd5,
        CFG_GATE_HOLD       = 3'd6,
        CFG_REPEAT_FRAMES   = 3'd7
    } cfg_index_t;

    localparam int FX_ALT_SWEEP = 0;
    localparam int FX_ONE_SWEEP = 1;
    localparam int FX_GATE      = 2;

    typedef struct packed {
        logic               playback_enable;
        logic [2:0]         effect_flags;
        logic signed [15:0] sweep_step;
        logic [15:0]        sweep_trigger;
        logic [15:0]        sweep_hold;
        logic [15:0]        gate_trigger;
        logic [15:0]        gate_hold;
        logic [15:0]        repeat_frames;
    } cfg_t;

    typedef struct packed {
        logic        command;
        logic [15:0] start_frames;
        logic [1:0]  start_loop_mode;
        logic [7:0]  start_loop_count;
        logic [15:0] start_frequency;
    } in_item_t;

    typedef struct packed {
        logic        sound_off;
        logic [15:0] frequency;
        logic        active;
    } result_t;

endpackage

// ===== design/stsq_cfg.sv =====
`timescale 1ns / 1ps

module stsq_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [stsq_pkg::CFG_IDX_BITS-1:0]  wr_index,
    input  logic [stsq_pkg::CFG_DATA_BITS-1:0] wr_data,
    output stsq_pkg::cfg_t                cfg
);
    import stsq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                CFG_PLAYBACK_ENABLE: cfg_next.playback_enable = wr_data[0];
                CFG_EFFECT_FLAGS:    cfg_next.effect_flags    = wr_data[2:0];
                CFG_SWEEP_STEP:      cfg_next.sweep_step      = $signed(wr_data[15:0]);
                CFG_SWEEP_TRIGGER:   cfg_next.sweep_trigger   = wr_data[15:0];
                CFG_SWEEP_HOLD:      cfg_next.sweep_hold      = wr_data[15:0];
                CFG_GATE_TRIGGER:    cfg_next.gate_trigger    = wr_data[15:0];
                CFG_GATE_HOLD:       cfg_next.gate_hold       = wr_data[15:0];
                CFG_REPEAT_FRAMES:   cfg_next.repeat_frames   = wr_data[15:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{playback_enable: 1'b1, default: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/stsq_in_stage.sv =====
`timescale 1ns / 1ps

module stsq_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  stsq_pkg::in_item_t in_item,
    input  logic               out_free,
    output logic               advance,
    output stsq_pkg::in_item_t item
);
    import stsq_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign advance  = valid_reg && out_free;
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item = item_reg;

endmodule

// ===== design/stsq_core.sv =====
`timescale 1ns / 1ps

module stsq_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  stsq_pkg::in_item_t item,
    input  stsq_pkg::cfg_t     cfg,
    output stsq_pkg::result_t  result
);
    import stsq_pkg::*;

    logic [COUNT_BITS-1:0] frames_reg,  frames_next;
    loop_mode_t            loop_reg,    loop_next;
    logic [7:0]            repeats_reg, repeats_next;
    logic [FREQ_BITS-1:0]  freq_reg,    freq_next;
    logic [COUNT_BITS-1:0] sweep_reg,   sweep_next;
    logic [COUNT_BITS-1:0] gate_reg,    gate_next;

    logic [COUNT_BITS-1:0] frames_dec;
    logic [FREQ_BITS-1:0]  step_pos;
    logic [FREQ_BITS-1:0]  step_neg;
    logic [FREQ_BITS-1:0]  step_alt;
    logic [COUNT_BITS-1:0] sweep_a;
    logic [FREQ_BITS-1:0]  freq_a;
    logic [COUNT_BITS-1:0] sweep_b;
    logic [FREQ_BITS-1:0]  freq_b;
    logic [COUNT_BITS-1:0] gate_inc;
    logic                  gate_fire;
    logic                  off;

    assign frames_dec = frames_reg - 1'b1;
    assign step_pos   = FREQ_BITS'(cfg.sweep_step);
    assign step_neg   = -step_pos;
    assign step_alt   = frames_dec[0] ? step_neg : step_pos;

    // alternating sweep runs first, one-way sweep sees its result
    always_comb
    begin
        sweep_a = sweep_reg;
        freq_a  = freq_reg;
        if (cfg.effect_flags[FX_ALT_SWEEP])
        begin
            sweep_a = sweep_reg + 1'b1;
            if (CMP_BITS'(sweep_a) > CMP_BITS'(cfg.sweep_trigger))
            begin
                freq_a = freq_reg + step_alt;
                if (CMP_BITS'(sweep_a) > CMP_BITS'(cfg.sweep_hold))
                begin
                    sweep_a = '0;
                end
            end
        end
        sweep_b = sweep_a;
        freq_b  = freq_a;
        if (cfg.effect_flags[FX_ONE_SWEEP])
        begin
            sweep_b = sweep_a + 1'b1;
            if (CMP_BITS'(sweep_b) > CMP_BITS'(cfg.sweep_trigger))
            begin
                freq_b = freq_a + step_pos;
                if (CMP_BITS'(sweep_b) > CMP_BITS'(cfg.sweep_hold))
                begin
                    sweep_b = '0;
                end
            end
        end
    end

    always_comb
    begin
        gate_inc  = gate_reg;
        gate_fire = 1'b0;
        if (cfg.effect_flags[FX_GATE])
        begin
            gate_inc = gate_reg + 1'b1;
            if (CMP_BITS'(gate_inc) > CMP_BITS'(cfg.gate_trigger))
            begin
                gate_fire = 1'b1;
                if (CMP_BITS'(gate_inc) > CMP_BITS'(cfg.gate_hold))
                begin
                    gate_inc = '0;
                end
            end
        end
    end

    always_comb
    begin
        frames_next  = frames_reg;
        loop_next    = loop_reg;
        repeats_next = repeats_reg;
        freq_next    = freq_reg;
        sweep_next   = sweep_reg;
        gate_next    = gate_reg;
        off          = 1'b0;
        if (item.command)
        begin
            frames_next  = COUNT_BITS'(item.start_frames);
            loop_next    = loop_mode_t'(item.start_loop_mode);
            repeats_next = item.start_loop_count;
            freq_next    = FREQ_BITS'(item.start_frequency);
        end
        else if (frames_reg != '0)
        begin
            frames_next = frames_dec;
            if (frames_dec == '0)
            begin
                if (loop_reg != LOOP_NONE)
                begin
                    frames_next = COUNT_BITS'(cfg.repeat_frames);
                    if (loop_reg == LOOP_REPEAT)
                    begin
                        loop_next = loop_reg;
                    end
                    else if (loop_reg == LOOP_COUNTED && repeats_reg != '0)
                    begin
                        repeats_next = repeats_reg - 1'b1;
                    end
                    else
                    begin
                        loop_next   = LOOP_NONE;
                        frames_next = '0;
                        off         = 1'b1;
                    end
                end
            end
            else if (!cfg.playback_enable)
            begin
                frames_next = '0;
                off         = 1'b1;
            end
            else
            begin
                sweep_next = sweep_b;
                freq_next  = freq_b;
                gate_next  = gate_inc;
                off        = gate_fire;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg  <= '0;
            loop_reg    <= LOOP_NONE;
            repeats_reg <= '0;
            freq_reg    <= '0;
            sweep_reg   <= '0;
            gate_reg    <= '0;
        end
        else if (advance)
        begin
            frames_reg  <= frames_next;
            loop_reg    <= loop_next;
            repeats_reg <= repeats_next;
            freq_reg    <= freq_next;
            sweep_reg   <= sweep_next;
            gate_reg    <= gate_next;
        end
    end

    assign result.sound_off = off;
    assign result.frequency = 16'(freq_next);
    assign result.active    = (frames_next != '0);

endmodule

// ===== design/stsq_out_stage.sv =====
`timescale 1ns / 1ps

module stsq_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  stsq_pkg::result_t result,
    output logic              out_free,
    output logic              out_valid,
    input  logic              out_ready,
    output stsq_pkg::result_t out_result
);
    import stsq_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ===== design/sound_effect_tick_sequencer.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake                  | Content
// ---------+----------------------------+-----------------------------------------
// s        | s_tvalid / s_tready        | one command beat (tick or start)
// m        | m_tvalid / m_tready        | one result beat per command beat
// cfg      | cfg_valid / cfg_ready      | register write, index and data
//
// One beat per cycle sustained unless m_tready stalls the output register.
// The input register feeds a single pass of counter and sweep logic into the
// output register; the state registers update in the same cycle.
// Reset clears the sequencer state; playback_enable resets to 1, other registers to 0.
// A stalled output holds one result while one more command beat waits in the input register.

module sound_effect_tick_sequencer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // start_frames[15:0], start_loop_mode[17:16], start_loop_count[25:18],
    // start_frequency[41:26], zero [47:42]
    input  logic [stsq_pkg::IN_DATA_BITS-1:0]     s_tdata,
    // command[0]
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // sound_off[0], frequency[16:1], active[17], zero [23:18]
    output logic [stsq_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [stsq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [stsq_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import stsq_pkg::*;

    in_item_t in_item;
    in_item_t item;
    cfg_t     cfg;
    result_t  result;
    result_t  out_result;
    logic     out_free;
    logic     advance;

    assign in_item.command          = s_tuser;
    assign in_item.start_frames     = s_tdata[15:0];
    assign in_item.start_loop_mode  = s_tdata[17:16];
    assign in_item.start_loop_count = s_tdata[25:18];
    assign in_item.start_frequency  = s_tdata[41:26];

    assign cfg_ready = 1'b1;

    stsq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    stsq_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .out_free (out_free),
        .advance  (advance),
        .item     (item)
    );

    stsq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    stsq_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result     (result),
        .out_free   (out_free),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {6'd0, out_result.active, out_result.frequency, out_result.sound_off};

endmodule
